@@ hdl/l2mlf_pkg.sv @@
`default_nettype none

package l2mlf_pkg;

    localparam int SW_W   = 2;
    localparam int PORT_W = 3;
    localparam int MAC_W  = 48;
    localparam int MASK_W = 4;

    typedef struct packed {
        logic [SW_W-1:0]   switch_id;
        logic [PORT_W-1:0] in_port;
        logic [MAC_W-1:0]  src_mac;
        logic [MAC_W-1:0]  dst_mac;
    } l2mlf_hdr_t;

    typedef struct packed {
        logic [MASK_W-1:0] out_port_mask;
        logic              flooded;
        logic              learn_dropped;
    } l2mlf_fwd_t;

    typedef struct packed {
        logic       en;
        l2mlf_hdr_t hdr;
    } l2mlf_req_t;

endpackage

`default_nettype wire

@@ hdl/l2mlf_cam.sv @@
`default_nettype none

module l2mlf_cam #(
    parameter int NUM_PORTS     = 4,
    parameter int NUM_SWITCHES  = 4,
    parameter int TABLE_ENTRIES = 16
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire l2mlf_pkg::l2mlf_req_t req,
    output l2mlf_pkg::l2mlf_fwd_t      rsp
);

    localparam int MAX_TABLES = 1 << l2mlf_pkg::SW_W;
    localparam int NUM_TABLES = (NUM_SWITCHES < MAX_TABLES) ? NUM_SWITCHES : MAX_TABLES;
    localparam int TBL_W      = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
    localparam int TE         = TABLE_ENTRIES;

    logic [l2mlf_pkg::MAC_W-1:0]  keys_reg  [NUM_TABLES][TE];
    logic [l2mlf_pkg::PORT_W-1:0] ports_reg [NUM_TABLES][TE];
    logic [TE-1:0]                valid_reg [NUM_TABLES];

    logic                         sw_ok;
    logic [TBL_W-1:0]             tbl;
    logic [l2mlf_pkg::MAC_W-1:0]  row_key  [TE];
    logic [l2mlf_pkg::PORT_W-1:0] row_port [TE];
    logic [TE-1:0]                row_valid;
    logic [TE-1:0]                src_hit;
    logic [TE-1:0]                dst_hit;
    logic [TE-1:0]                free_oh;
    logic [TE-1:0]                wr_en;
    logic [l2mlf_pkg::PORT_W-1:0] hit_port;
    logic [l2mlf_pkg::PORT_W-1:0] fwd_port;
    logic                         any_src;
    logic                         dropped;
    logic                         learn;
    logic                         same_mac;
    logic                         found;
    logic [l2mlf_pkg::MASK_W-1:0] uni_mask;
    logic [l2mlf_pkg::MASK_W-1:0] flood_mask;

    assign sw_ok = 32'(req.hdr.switch_id) < NUM_SWITCHES;
    assign tbl   = sw_ok ? TBL_W'(req.hdr.switch_id) : '0;

    always_comb
    begin
        row_valid = valid_reg[tbl];
        hit_port  = '0;
        for (int i = 0; i < TE; i++)
        begin
            row_key[i]  = keys_reg[tbl][i];
            row_port[i] = ports_reg[tbl][i];
            src_hit[i]  = row_valid[i] && (row_key[i] == req.hdr.src_mac);
            dst_hit[i]  = row_valid[i] && (row_key[i] == req.hdr.dst_mac);
            hit_port    = hit_port | (dst_hit[i] ? row_port[i] : '0);
        end
    end

    assign any_src = |src_hit;
    assign free_oh = ~row_valid & (row_valid + TE'(1));
    assign dropped = sw_ok && !any_src && (&row_valid);
    assign learn   = req.en && sw_ok && !dropped;
    assign wr_en   = learn ? (any_src ? src_hit : free_oh) : '0;

    // keys are unique in a table, so the learned source is the only new match
    assign same_mac = (req.hdr.src_mac == req.hdr.dst_mac) && !dropped;
    assign found    = same_mac || (|dst_hit);
    assign fwd_port = same_mac ? req.hdr.in_port : hit_port;

    always_comb
    begin
        for (int k = 0; k < l2mlf_pkg::MASK_W; k++)
        begin
            uni_mask[k]   = (k < NUM_PORTS) && (fwd_port == l2mlf_pkg::PORT_W'(k + 1));
            flood_mask[k] = (k < NUM_PORTS) && (req.hdr.in_port != l2mlf_pkg::PORT_W'(k + 1));
        end
    end

    always_comb
    begin
        rsp.learn_dropped = dropped;
        if (!sw_ok || !found || (fwd_port == '0))
        begin
            rsp.flooded       = 1'b1;
            rsp.out_port_mask = flood_mask;
        end
        else
        begin
            rsp.flooded       = 1'b0;
            rsp.out_port_mask = uni_mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < NUM_TABLES; t++)
            begin
                valid_reg[t] <= '0;
            end
        end
        else
        begin
            for (int t = 0; t < NUM_TABLES; t++)
            begin
                if (tbl == TBL_W'(t))
                begin
                    valid_reg[t] <= valid_reg[t] | wr_en;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int t = 0; t < NUM_TABLES; t++)
        begin
            for (int i = 0; i < TE; i++)
            begin
                if (wr_en[i] && (tbl == TBL_W'(t)))
                begin
                    keys_reg[t][i]  <= req.hdr.src_mac;
                    ports_reg[t][i] <= req.hdr.in_port;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/l2_mac_learning_forwarder_unit.sv @@
// MAC learning forwarder.
// Takes one frame header per item on the hdr channel (valid/ready): switch
// number, ingress port and source and destination MACs. Returns one forwarding
// decision per item on the fwd channel: egress port mask, a flood flag and a
// flag for a source that could not be learned because its table was full.
// Each switch owns a fully associative table of TABLE_ENTRIES entries, all
// compared in parallel; the source is learned and the destination looked up
// in the same cycle, so the next item already sees the updated table.
// A header is held in the header register, then the table search feeds the
// result register, which drives fwd_valid. Throughput is one item per cycle
// while the fwd channel takes its results, since the table is searched and
// written with no extra stage.
// A stalled fwd channel holds its result; the header stage still takes one
// more item, after which hdr_ready drops until the result is taken.
// Reset clears every table entry's valid bit and empties both stages; no
// clearing pass is needed, the block takes items right after reset.
`default_nettype none

module l2_mac_learning_forwarder_unit #(
    parameter int NUM_PORTS     = 4,
    parameter int NUM_SWITCHES  = 4,
    parameter int TABLE_ENTRIES = 16
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        hdr_valid,
    output logic                       hdr_ready,
    input  wire l2mlf_pkg::l2mlf_hdr_t hdr,
    output logic                       fwd_valid,
    input  wire                        fwd_ready,
    output l2mlf_pkg::l2mlf_fwd_t      fwd
);

    l2mlf_pkg::l2mlf_hdr_t hdr_reg;
    logic                  hdr_valid_reg;
    l2mlf_pkg::l2mlf_fwd_t fwd_reg;
    logic                  fwd_valid_reg;
    logic                  advance;
    l2mlf_pkg::l2mlf_req_t cam_req;
    l2mlf_pkg::l2mlf_fwd_t cam_rsp;

    assign advance   = hdr_valid_reg && (!fwd_valid_reg || fwd_ready);
    assign hdr_ready = !hdr_valid_reg || advance;
    assign fwd_valid = fwd_valid_reg;
    assign fwd       = fwd_reg;

    assign cam_req = '{en: advance, hdr: hdr_reg};

    l2mlf_cam #(
        .NUM_PORTS     (NUM_PORTS),
        .NUM_SWITCHES  (NUM_SWITCHES),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_cam (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cam_req),
        .rsp   (cam_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            if (hdr_ready)
            begin
                hdr_valid_reg <= hdr_valid;
            end
            if (advance)
            begin
                fwd_valid_reg <= 1'b1;
            end
            else if (fwd_ready)
            begin
                fwd_valid_reg <= 1'b0;
            end
        end
    end

    // hold payloads while their stage is stalled
    always_ff @(posedge clk)
    begin
        if (hdr_valid && hdr_ready)
        begin
            hdr_reg <= hdr;
        end
        if (advance)
        begin
            fwd_reg <= cam_rsp;
        end
    end

endmodule

`default_nettype wire

@@ hdl/l2mlf_checker.sv @@
`default_nettype none

module l2mlf_checker (
    input wire                        clk,
    input wire                        rst_n,
    input wire                        hdr_valid,
    input wire                        hdr_ready,
    input wire l2mlf_pkg::l2mlf_hdr_t hdr,
    input wire                        fwd_valid,
    input wire                        fwd_ready,
    input wire l2mlf_pkg::l2mlf_fwd_t fwd
);

    a_hdr_hold: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_valid && !hdr_ready |=> hdr_valid && $stable(hdr))
        else $error("hdr item changed while waiting");

    a_fwd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_valid && !fwd_ready |=> fwd_valid && $stable(fwd))
        else $error("fwd item changed while stalled");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_valid && hdr_ready |-> ##2 fwd_valid)
        else $error("no fwd item two cycles after hdr acceptance");

    a_unicast: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_valid && !fwd.flooded |-> $onehot0(fwd.out_port_mask))
        else $error("forwarded item names more than one port");

    a_flood: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_valid && fwd.flooded |-> (fwd.out_port_mask != '0))
        else $error("flooded item has an empty port mask");

endmodule

bind l2_mac_learning_forwarder_unit l2mlf_checker u_l2mlf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .hdr_valid (hdr_valid),
    .hdr_ready (hdr_ready),
    .hdr       (hdr),
    .fwd_valid (fwd_valid),
    .fwd_ready (fwd_ready),
    .fwd       (fwd)
);

`default_nettype wire

@@ sim/l2_mac_learning_forwarder_unit_tb.sv @@
`default_nettype none

module l2_mac_learning_forwarder_unit_tb;

    localparam int NUM_PORTS     = 4;
    localparam int NUM_SWITCHES  = 4;
    localparam int TABLE_ENTRIES = 16;
    localparam int TOTAL_SLOTS   = NUM_SWITCHES * TABLE_ENTRIES;
    localparam int RANDOM_ITEMS  = 700;
    localparam int POOL_SIZE     = 24;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 8;

    class fwd_scoreboard;
        logic [l2mlf_pkg::MAC_W-1:0]  stored_mac  [TOTAL_SLOTS];
        logic [l2mlf_pkg::PORT_W-1:0] stored_port [TOTAL_SLOTS];
        bit                           entry_used  [TOTAL_SLOTS];
        l2mlf_pkg::l2mlf_fwd_t        expected_q  [$];
        int                           errors;

        function new();
            foreach (entry_used[i])
                entry_used[i] = 1'b0;
            errors = 0;
        endfunction

        function int lookup(int base, logic [l2mlf_pkg::MAC_W-1:0] key);
            int found;
            found = -1;
            for (int i = 0; i < TABLE_ENTRIES; i++)
                if (found < 0 && entry_used[base+i] && stored_mac[base+i] == key)
                    found = i;
            return found;
        endfunction

        function logic [l2mlf_pkg::MASK_W-1:0] flood_ports(logic [l2mlf_pkg::PORT_W-1:0] port);
            logic [l2mlf_pkg::MASK_W-1:0] m;
            m = l2mlf_pkg::MASK_W'((1 << NUM_PORTS) - 1);
            if (port >= 1 && port <= NUM_PORTS)
                m[port-1] = 1'b0;
            return m;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_header(l2mlf_pkg::l2mlf_hdr_t h);
            int                           base;
            int                           hit;
            int                           free_slot;
            int                           d;
            logic [l2mlf_pkg::PORT_W-1:0] p;
            l2mlf_pkg::l2mlf_fwd_t        r;
            r = '0;
            if (h.switch_id >= NUM_SWITCHES)
            begin
                r.out_port_mask = flood_ports(h.in_port);
                r.flooded = 1'b1;
            end
            else
            begin
                base = h.switch_id * TABLE_ENTRIES;
                hit = lookup(base, h.src_mac);
                if (hit >= 0)
                begin
                    stored_port[base+hit] = h.in_port;
                end
                else
                begin
                    free_slot = -1;
                    for (int i = 0; i < TABLE_ENTRIES; i++)
                        if (free_slot < 0 && !entry_used[base+i])
                            free_slot = i;
                    if (free_slot >= 0)
                    begin
                        stored_mac[base+free_slot]  = h.src_mac;
                        stored_port[base+free_slot] = h.in_port;
                        entry_used[base+free_slot]  = 1'b1;
                    end
                    else
                    begin
                        r.learn_dropped = 1'b1;
                    end
                end
                d = lookup(base, h.dst_mac);
                if (d >= 0 && stored_port[base+d] != 0)
                begin
                    p = stored_port[base+d];
                    r.out_port_mask = (p <= NUM_PORTS) ?
                                      l2mlf_pkg::MASK_W'(1 << (p - 1)) : '0;
                end
                else
                begin
                    r.out_port_mask = flood_ports(h.in_port);
                    r.flooded = 1'b1;
                end
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(l2mlf_pkg::l2mlf_fwd_t got);
            l2mlf_pkg::l2mlf_fwd_t want;
            if (expected_q.size() == 0)
            begin
                $error("fwd item with nothing expected: %0h", got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.out_port_mask !== want.out_port_mask)
            begin
                $error("out_port_mask: expected %0h, got %0h",
                       want.out_port_mask, got.out_port_mask);
                errors++;
            end
            if (got.flooded !== want.flooded)
            begin
                $error("flooded: expected %0b, got %0b", want.flooded, got.flooded);
                errors++;
            end
            if (got.learn_dropped !== want.learn_dropped)
            begin
                $error("learn_dropped: expected %0b, got %0b",
                       want.learn_dropped, got.learn_dropped);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  hdr_valid;
    logic                  hdr_ready;
    l2mlf_pkg::l2mlf_hdr_t hdr;
    logic                  fwd_valid;
    logic                  fwd_ready;
    l2mlf_pkg::l2mlf_fwd_t fwd;

    fwd_scoreboard               sb;
    bit                          calm;
    int                          cycles;
    logic [l2mlf_pkg::MAC_W-1:0] mac_pool [POOL_SIZE];

    l2_mac_learning_forwarder_unit #(
        .NUM_PORTS     (NUM_PORTS),
        .NUM_SWITCHES  (NUM_SWITCHES),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .hdr_valid (hdr_valid),
        .hdr_ready (hdr_ready),
        .hdr       (hdr),
        .fwd_valid (fwd_valid),
        .fwd_ready (fwd_ready),
        .fwd       (fwd)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic l2mlf_pkg::l2mlf_hdr_t make_hdr(int sw, int port,
                                                       logic [l2mlf_pkg::MAC_W-1:0] src,
                                                       logic [l2mlf_pkg::MAC_W-1:0] dst);
        l2mlf_pkg::l2mlf_hdr_t h;
        h.switch_id = l2mlf_pkg::SW_W'(sw);
        h.in_port   = l2mlf_pkg::PORT_W'(port);
        h.src_mac   = src;
        h.dst_mac   = dst;
        return h;
    endfunction

    function automatic logic [l2mlf_pkg::MAC_W-1:0] random_mac();
        return l2mlf_pkg::MAC_W'({$urandom, $urandom});
    endfunction

    function automatic logic [l2mlf_pkg::MAC_W-1:0] pick_mac();
        if ($urandom_range(0, 99) < 85)
            return mac_pool[$urandom_range(0, POOL_SIZE - 1)];
        return random_mac();
    endfunction

    function automatic int pick_port();
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(1, NUM_PORTS);
        return $urandom_range(0, 7);
    endfunction

    task automatic send_header(l2mlf_pkg::l2mlf_hdr_t h);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 33)
        begin
            hdr_valid <= 1'b0;
            hdr       <= make_hdr($urandom, $urandom, random_mac(), random_mac());
            @(negedge clk);
        end
        hdr_valid <= 1'b1;
        hdr       <= h;
        do
            @(posedge clk);
        while (!hdr_ready);
    endtask

    task automatic drain();
        @(negedge clk);
        hdr_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    always @(negedge clk)
        if (!rst_n)
            fwd_ready <= 1'b0;
        else
            fwd_ready <= calm || ($urandom_range(0, 99) >= 33);

    always @(posedge clk)
    begin
        cycles++;
        if (rst_n)
        begin
            if (hdr_valid && hdr_ready)
                sb.note_header(hdr);
            if (fwd_valid && fwd_ready)
                sb.check_result(fwd);
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        sb        = new();
        calm      = 1'b0;
        cycles    = 0;
        rst_n     = 1'b0;
        hdr_valid = 1'b0;
        hdr       = '0;
        foreach (mac_pool[i])
            mac_pool[i] = random_mac();
        mac_pool[0] = '0;
        mac_pool[1] = '1;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_header(make_hdr(0, 1, 48'h0000_0000_00a1, 48'h0000_0000_00a1));
        send_header(make_hdr(0, 2, 48'h0000_0000_00b2, 48'h0000_0000_00c3));
        send_header(make_hdr(0, 3, 48'h0000_0000_00c3, 48'h0000_0000_00a1));
        send_header(make_hdr(0, 0, 48'h0000_0000_00d4, 48'h0000_0000_00d4));
        send_header(make_hdr(0, 7, 48'h0000_0000_00e5, 48'h0000_0000_00e5));
        send_header(make_hdr(0, 5, 48'h0000_0000_00f6, 48'h0000_0000_00f6));
        send_header(make_hdr(0, 6, 48'h0000_0000_0000, 48'hffff_ffff_ffff));
        send_header(make_hdr(0, 4, 48'hffff_ffff_ffff, 48'h0000_0000_0000));
        send_header(make_hdr(1, 2, 48'h0000_0000_00a1, 48'h0000_0000_00a1));
        send_header(make_hdr(2, 4, 48'h0000_0000_00b2, 48'h0000_0000_00a1));
        send_header(make_hdr(3, 1, 48'haaaa_aaaa_aaaa, 48'h5555_5555_5555));
        send_header(make_hdr(0, 2, 48'h0000_0000_00a1, 48'h0000_0000_00a1));
        // fill one table, then overflow it
        for (int i = 1; i <= TABLE_ENTRIES; i++)
            send_header(make_hdr(3, (i % NUM_PORTS) + 1, 48'h0000_0000_1000 + i,
                                 48'h0000_0000_1000 + i - 1));

        drain();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm = (n >= 300 && n < 420);
            send_header(make_hdr($urandom_range(0, NUM_SWITCHES - 1), pick_port(),
                                 pick_mac(), pick_mac()));
        end
        calm = 1'b0;

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

@@ l2_mac_learning_forwarder_unit.f @@
hdl/l2mlf_pkg.sv
hdl/l2mlf_cam.sv
hdl/l2_mac_learning_forwarder_unit.sv
hdl/l2mlf_checker.sv
sim/l2_mac_learning_forwarder_unit_tb.sv
